### rtl/qafs_pkg.sv
// Shared types, constants and helpers of the quote-aware field splitter.
package qafs_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int DEPTH_MAX  = 255;
    localparam int DEPTH_W    = $clog2(DEPTH_MAX + 1);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LROUND   = 8'h28;
    localparam logic [7:0] CH_RROUND   = 8'h29;
    localparam logic [7:0] CH_LSQUARE  = 8'h5B;
    localparam logic [7:0] CH_RSQUARE  = 8'h5D;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam logic REG_DELIMITER = 1'b0;

    typedef enum logic [1:0] {
        QK_NONE,
        QK_SINGLE,
        QK_DOUBLE
    } t_quote;

    typedef enum logic [1:0] {
        CMD_CONTENT,
        CMD_SPACE,
        CMD_FIELD_END
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_FLUSH
    } t_back_state;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

### rtl/qafs_in_if.sv
// Input channel of the splitter: one text byte or an end marker per beat.
interface qafs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

### rtl/qafs_out_if.sv
// Result channel of the splitter: one field byte or field end per beat.
interface qafs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       field_end;
    logic       trim_overflow;
    logic       run_last;

    modport source (output valid, output out_byte, output has_byte, output field_end,
                    output trim_overflow, output run_last, input ready);
    modport sink (input valid, input out_byte, input has_byte, input field_end,
                  input trim_overflow, input run_last, output ready);
endinterface

### rtl/qafs_front.sv
// Front end: tracks quotes, escapes and bracket depths and classifies each byte.
module qafs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qafs_in_if.sink       i_in,
    input  logic [7:0]    i_delim,
    input  logic          i_full,
    output logic          o_push,
    output qafs_pkg::t_cmd o_cmd
);
    import qafs_pkg::*;

    t_quote              r_quote, n_quote;
    logic                r_esc, n_esc;
    logic [DEPTH_W-1:0]  r_round, n_round;
    logic [DEPTH_W-1:0]  r_square, n_square;
    logic                r_started, n_started;
    logic                r_seen, n_seen;
    logic                accept;
    logic                do_content;
    logic                cmd_valid;
    logic [7:0]          c;
    logic [7:0]          closer;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept && cmd_valid;
    assign c          = i_in.in_byte;
    assign closer     = (r_quote == QK_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

    always_comb begin
        n_quote    = r_quote;
        n_esc      = r_esc;
        n_round    = r_round;
        n_square   = r_square;
        n_started  = r_started;
        n_seen     = r_seen;
        do_content = 1'b0;
        cmd_valid  = 1'b0;
        o_cmd.kind = CMD_FIELD_END;
        o_cmd.data = c;
        if (i_in.end_of_text) begin
            cmd_valid = r_seen;
            n_quote   = QK_NONE;
            n_esc     = 1'b0;
            n_round   = '0;
            n_square  = '0;
            n_started = 1'b0;
            n_seen    = 1'b0;
        end else begin
            n_seen = 1'b1;
            if (r_esc) begin
                n_esc      = 1'b0;
                do_content = 1'b1;
            end else if (r_quote != QK_NONE && c == CH_BSLASH) begin
                n_esc      = 1'b1;
                do_content = 1'b1;
            end else if (r_quote != QK_NONE) begin
                if (c == closer) begin
                    n_quote = QK_NONE;
                end
                do_content = 1'b1;
            end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                n_quote    = (c == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                do_content = 1'b1;
            end else begin
                if (c == CH_LROUND) begin
                    if (r_round < DEPTH_W'(DEPTH_MAX)) begin
                        n_round = r_round + 1'b1;
                    end
                end else if (c == CH_RROUND) begin
                    if (r_round != '0) begin
                        n_round = r_round - 1'b1;
                    end
                end else if (c == CH_LSQUARE) begin
                    if (r_square < DEPTH_W'(DEPTH_MAX)) begin
                        n_square = r_square + 1'b1;
                    end
                end else if (c == CH_RSQUARE) begin
                    if (r_square != '0) begin
                        n_square = r_square - 1'b1;
                    end
                end
                if (c == i_delim && n_round == '0 && n_square == '0) begin
                    cmd_valid = 1'b1;
                    n_started = 1'b0;
                end else begin
                    do_content = 1'b1;
                end
            end
            if (do_content) begin
                if (is_space(c)) begin
                    cmd_valid  = r_started;
                    o_cmd.kind = CMD_SPACE;
                end else begin
                    cmd_valid  = 1'b1;
                    o_cmd.kind = CMD_CONTENT;
                    n_started  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote   <= QK_NONE;
            r_esc     <= 1'b0;
            r_round   <= '0;
            r_square  <= '0;
            r_started <= 1'b0;
            r_seen    <= 1'b0;
        end else if (accept) begin
            r_quote   <= n_quote;
            r_esc     <= n_esc;
            r_round   <= n_round;
            r_square  <= n_square;
            r_started <= n_started;
            r_seen    <= n_seen;
        end
    end

endmodule

### rtl/qafs_queue.sv
// Short command queue between the front end and the back end.
module qafs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qafs_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output qafs_pkg::t_cmd o_head,
    output logic           o_empty
);
    import qafs_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QAW-1:0]    r_wr, n_wr;
    logic [QAW-1:0]    r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### rtl/qafs_back.sv
// Back end: holds inner whitespace, flushes it and drives the result register.
module qafs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qafs_pkg::t_cmd i_head,
    input  logic           i_empty,
    output logic           o_pop,
    qafs_out_if.source     o_out
);
    import qafs_pkg::*;

    t_back_state        r_state, n_state;
    logic [7:0]         r_held [HOLD_DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [HOLD_AW-1:0] r_idx, n_idx;
    logic               r_valid;
    logic [7:0]         r_byte;
    logic               r_has, r_fend, r_ovf, r_last;
    logic               step;
    logic               full;
    logic               flast;
    logic               emit, e_has, e_fend, e_ovf, e_last;
    logic [7:0]         e_byte;
    logic               wr_en;
    logic [HOLD_AW-1:0] wr_idx;

    assign step  = !r_valid || o_out.ready;
    assign full  = (r_count == CNT_W'(HOLD_DEPTH));
    assign flast = (CNT_W'(r_idx) + 1'b1) == r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && step) begin
                    if ((i_head.kind == CMD_CONTENT && r_count != '0)
                        || (i_head.kind == CMD_SPACE && full)) begin
                        n_state = BK_FLUSH;
                    end
                end
            end
            BK_FLUSH: begin
                if (step && flast) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        emit    = 1'b0;
        e_byte  = 8'd0;
        e_has   = 1'b0;
        e_fend  = 1'b0;
        e_ovf   = 1'b0;
        e_last  = 1'b0;
        o_pop   = 1'b0;
        wr_en   = 1'b0;
        wr_idx  = r_count[HOLD_AW-1:0];
        n_count = r_count;
        n_idx   = r_idx;
        unique case (r_state)
            BK_IDLE: begin
                n_idx = '0;
                if (!i_empty && step) begin
                    unique case (i_head.kind)
                        CMD_CONTENT: begin
                            if (r_count == '0) begin
                                emit   = 1'b1;
                                e_byte = i_head.data;
                                e_has  = 1'b1;
                                e_last = 1'b1;
                                o_pop  = 1'b1;
                            end
                        end
                        CMD_SPACE: begin
                            if (!full) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                o_pop   = 1'b1;
                            end
                        end
                        CMD_FIELD_END: begin
                            emit    = 1'b1;
                            e_fend  = 1'b1;
                            e_last  = 1'b1;
                            n_count = '0;
                            o_pop   = 1'b1;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FLUSH: begin
                if (step) begin
                    emit   = 1'b1;
                    e_byte = r_held[r_idx];
                    e_has  = 1'b1;
                    e_ovf  = (i_head.kind == CMD_SPACE);
                    e_last = e_ovf && flast;
                    if (flast) begin
                        n_count = '0;
                        if (i_head.kind == CMD_SPACE) begin
                            wr_en   = 1'b1;
                            wr_idx  = '0;
                            n_count = CNT_W'(1);
                            o_pop   = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (step) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= e_byte;
            r_has  <= e_has;
            r_fend <= e_fend;
            r_ovf  <= e_ovf;
            r_last <= e_last;
        end
        if (wr_en) begin
            r_held[wr_idx] <= i_head.data;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_byte;
    assign o_out.has_byte      = r_has;
    assign o_out.field_end     = r_fend;
    assign o_out.trim_overflow = r_ovf;
    assign o_out.run_last      = r_last;

endmodule

### rtl/quote_aware_field_splitter.sv
// Top level of the quote-aware field splitter with its register port.
//
// The splitter takes one text byte per beat and returns trimmed field bytes and
// field ends, splitting at the delimiter register (byte address 0, reset ',')
// only outside quotes and at zero round and square bracket depth. The front end
// classifies each byte combinationally and feeds a four-entry command queue, so
// input beats are taken every cycle while the queue has room. The back end sets
// the sustained rate: a byte that needs no flush passes straight through, while
// a non-space byte with held whitespace, or a whitespace byte with a full hold
// store, waits until the held bytes are flushed through the single read port of
// the hold store, which emits one byte per cycle while the output is not stalled.
module quote_aware_field_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qafs_in_if.sink     i_in,
    qafs_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qafs_pkg::*;

    logic [7:0] r_delim;
    logic       cfg_wr;
    logic       push, full, pop, empty;
    t_cmd       cmd, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DELIMITER);
    assign prdata = (paddr[2] == REG_DELIMITER) ? {24'd0, r_delim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (cfg_wr) begin
            r_delim <= pwdata[7:0];
        end
    end

    qafs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_delim (r_delim),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    qafs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    qafs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
